// ----- rtl/core/m3inv_pkg.sv -----
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared constants and types for the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package m3inv_pkg;

    localparam int DET_W     = 64;
    localparam int RCP_SHIFT = 56;
    localparam int DIV_BITS  = RCP_SHIFT + 1;
    localparam int RES_W     = 32;
    localparam int RL_W      = 32;
    localparam int RH_W      = DIV_BITS - RL_W;

    localparam logic [RES_W-1:0] RES_MAX     = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] RES_NEG_MAG = 32'h8000_0000;

    typedef struct packed {
        logic [DET_W-1:0]    dm;
        logic [DET_W:0]      rem;
        logic [DIV_BITS-1:0] quo;
    } div_t;

endpackage

// ----- rtl/core/m3inv_front.sv -----
// ----------------------------------------------------------------------------
// m3inv_front
// Cofactors, optional transpose and determinant magnitude (three stages).
// ----------------------------------------------------------------------------
module m3inv_front #(
    parameter int W = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic                     func,
    input  logic [8:0][W-1:0]        m,
    output logic                     out_valid,
    output logic [8:0][2*W:0]        cof,
    output logic                     det_neg,
    output logic                     det_zero,
    output m3inv_pkg::div_t          dstate
);

    localparam int CW   = 2 * W + 1;
    localparam int PW   = W + CW;
    localparam int SUMW = (PW + 2 > m3inv_pkg::DET_W) ? PW + 2 : m3inv_pkg::DET_W;

    logic signed [W-1:0]    a [9];
    logic signed [CW-1:0]   c1_next [9];
    logic signed [CW-1:0]   c1_reg [9];
    logic signed [W-1:0]    a0_reg [3];
    logic                   func1_reg;
    logic signed [PW-1:0]   dp_next [3];
    logic signed [PW-1:0]   dp_reg [3];
    logic signed [CW-1:0]   c2_reg [9];
    logic                   func2_reg;
    logic signed [CW-1:0]   cof3_next [9];
    logic signed [CW-1:0]   cof3_reg [9];
    logic signed [SUMW-1:0] sum;
    logic [m3inv_pkg::DET_W-1:0] det;
    logic [m3inv_pkg::DET_W-1:0] dm_next;
    logic [m3inv_pkg::DET_W-1:0] dm3_reg;
    logic                   neg3_reg;
    logic                   zero3_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            a[k] = $signed(m[k]);
        end
        c1_next[0] = a[4] * a[8] - a[5] * a[7];
        c1_next[1] = a[2] * a[7] - a[1] * a[8];
        c1_next[2] = a[1] * a[5] - a[2] * a[4];
        c1_next[3] = a[5] * a[6] - a[3] * a[8];
        c1_next[4] = a[0] * a[8] - a[2] * a[6];
        c1_next[5] = a[2] * a[3] - a[0] * a[5];
        c1_next[6] = a[3] * a[7] - a[4] * a[6];
        c1_next[7] = a[1] * a[6] - a[0] * a[7];
        c1_next[8] = a[0] * a[4] - a[1] * a[3];
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dp_next[j] = a0_reg[j] * c1_reg[j * 3];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cof3_next[i * 3 + j] = func2_reg ? c2_reg[j * 3 + i] : c2_reg[i * 3 + j];
            end
        end
        sum     = SUMW'(dp_reg[0]) + SUMW'(dp_reg[1]) + SUMW'(dp_reg[2]);
        det     = sum[m3inv_pkg::DET_W-1:0];
        dm_next = det[m3inv_pkg::DET_W-1] ? (~det + 64'd1) : det;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg <= func;
            for (int k = 0; k < 3; k++)
            begin
                a0_reg[k] <= a[k];
            end
            for (int k = 0; k < 9; k++)
            begin
                c1_reg[k]   <= c1_next[k];
                c2_reg[k]   <= c1_reg[k];
                cof3_reg[k] <= cof3_next[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                dp_reg[k] <= dp_next[k];
            end
            func2_reg <= func1_reg;
            dm3_reg   <= dm_next;
            neg3_reg  <= det[m3inv_pkg::DET_W-1];
            zero3_reg <= (det == '0);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            cof[k] = cof3_reg[k];
        end
    end

    assign out_valid = v3_reg;
    assign det_neg   = neg3_reg;
    assign det_zero  = zero3_reg;
    assign dstate    = '{dm: dm3_reg, rem: '0, quo: '0};

endmodule

// ----- rtl/core/m3inv_div_step.sv -----
// ----------------------------------------------------------------------------
// m3inv_div_step
// One restoring step of the reciprocal divide, one quotient bit per stage.
// ----------------------------------------------------------------------------
module m3inv_div_step #(
    parameter int BIT    = 56,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  m3inv_pkg::div_t       in_div,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output m3inv_pkg::div_t       out_div,
    output logic [SIDE_W-1:0]     out_side
);

    logic                          bit_in;
    logic [m3inv_pkg::DET_W:0]     r2;
    logic [m3inv_pkg::DET_W:0]     dmx;
    logic                          ge;
    m3inv_pkg::div_t               div_next;
    m3inv_pkg::div_t               div_reg;
    logic [SIDE_W-1:0]             side_reg;
    logic                          v_reg;

    always_comb
    begin
        bit_in            = (BIT == m3inv_pkg::RCP_SHIFT);
        r2                = {in_div.rem[m3inv_pkg::DET_W-1:0], bit_in};
        dmx               = {1'b0, in_div.dm};
        ge                = (r2 >= dmx);
        div_next          = in_div;
        div_next.rem      = ge ? (r2 - dmx) : r2;
        div_next.quo[BIT] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg  <= div_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = v_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/core/m3inv_scale.sv -----
// ----------------------------------------------------------------------------
// m3inv_scale
// Cofactor times reciprocal, shift by 32 and saturate (three stages).
// ----------------------------------------------------------------------------
module m3inv_scale #(
    parameter int CW = 33
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [8:0][CW-1:0]                    cof,
    input  logic [m3inv_pkg::DIV_BITS-1:0]        quo,
    input  logic                                  det_neg,
    input  logic                                  det_zero,
    output logic                                  out_valid,
    output logic                                  singular,
    output logic [8:0][m3inv_pkg::RES_W-1:0]      res
);

    localparam int CL  = (CW + 1) / 2;
    localparam int CH  = CW - CL;
    localparam int RL  = m3inv_pkg::RL_W;
    localparam int RH  = m3inv_pkg::RH_W;
    localparam int PWP = CW + m3inv_pkg::DIV_BITS;
    localparam int QW  = PWP - 31;

    logic [CW-1:0]      cm [9];
    logic [CL+RL-1:0]   pll_next [9];
    logic [CL+RH-1:0]   plh_next [9];
    logic [CH+RL-1:0]   phl_next [9];
    logic [CH+RH-1:0]   phh_next [9];
    logic [CL+RL-1:0]   pll_reg [9];
    logic [CL+RH-1:0]   plh_reg [9];
    logic [CH+RL-1:0]   phl_reg [9];
    logic [CH+RH-1:0]   phh_reg [9];
    logic [8:0]         na_reg;
    logic               za_reg;
    logic [PWP-1:0]     p_next [9];
    logic [PWP-1:0]     p_reg [9];
    logic [8:0]         nb_reg;
    logic               zb_reg;
    logic [QW-1:0]      q1 [9];
    logic [m3inv_pkg::RES_W-1:0] qs [9];
    logic [m3inv_pkg::RES_W-1:0] res_next [9];
    logic [m3inv_pkg::RES_W-1:0] res_reg [9];
    logic               zc_reg;
    logic               va_reg;
    logic               vb_reg;
    logic               vc_reg;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            cm[k]       = cof[k][CW-1] ? (~cof[k] + CW'(1)) : cof[k];
            pll_next[k] = cm[k][CL-1:0] * quo[RL-1:0];
            plh_next[k] = cm[k][CL-1:0] * quo[RL+RH-1:RL];
            phl_next[k] = cm[k][CW-1:CL] * quo[RL-1:0];
            phh_next[k] = cm[k][CW-1:CL] * quo[RL+RH-1:RL];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            p_next[k] = PWP'(pll_reg[k])
                      + (PWP'(plh_reg[k]) << RL)
                      + (PWP'(phl_reg[k]) << CL)
                      + (PWP'(phh_reg[k]) << (RL + CL));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            q1[k] = QW'(p_reg[k][PWP-1:32]) + QW'(|p_reg[k][31:0]);
            qs[k] = (q1[k] > QW'(m3inv_pkg::RES_NEG_MAG)) ? m3inv_pkg::RES_NEG_MAG
                                                          : q1[k][31:0];
            if (zb_reg)
            begin
                res_next[k] = '0;
            end
            else if (!nb_reg[k])
            begin
                res_next[k] = (|p_reg[k][PWP-1:63]) ? m3inv_pkg::RES_MAX
                                                    : {1'b0, p_reg[k][62:32]};
            end
            else
            begin
                res_next[k] = '0 - qs[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                pll_reg[k] <= pll_next[k];
                plh_reg[k] <= plh_next[k];
                phl_reg[k] <= phl_next[k];
                phh_reg[k] <= phh_next[k];
                na_reg[k]  <= cof[k][CW-1] ^ det_neg;
                p_reg[k]   <= p_next[k];
                res_reg[k] <= res_next[k];
            end
            za_reg <= det_zero;
            nb_reg <= na_reg;
            zb_reg <= za_reg;
            zc_reg <= zb_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            res[k] = res_reg[k];
        end
    end

    assign out_valid = vc_reg;
    assign singular  = zc_reg;

endmodule

// ----- rtl/core/matrix3_inverse_core.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Pipelined 3x3 fixed-point inverse / transposed inverse via the adjugate.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------
//   in      | in_valid/in_ready   | func, m00..m22 (signed Q8.8)
//   out     | out_valid/out_ready | singular, r00..r22 (signed Q16.16)
//
// One item per cycle while the output is not stalled. The path holds 3 front stages, 57 divide
// steps (one reciprocal bit each), 3 scale stages and the output register.
// Reset clears only the valid bits. A stalled output parks one item in a
// skid register; the whole pipeline then holds until it drains.
// ----------------------------------------------------------------------------
module matrix3_inverse_core #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [ELEM_WIDTH-1:0] m00,
    input  logic [ELEM_WIDTH-1:0] m01,
    input  logic [ELEM_WIDTH-1:0] m02,
    input  logic [ELEM_WIDTH-1:0] m10,
    input  logic [ELEM_WIDTH-1:0] m11,
    input  logic [ELEM_WIDTH-1:0] m12,
    input  logic [ELEM_WIDTH-1:0] m20,
    input  logic [ELEM_WIDTH-1:0] m21,
    input  logic [ELEM_WIDTH-1:0] m22,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  singular,
    output logic [31:0]           r00,
    output logic [31:0]           r01,
    output logic [31:0]           r02,
    output logic [31:0]           r10,
    output logic [31:0]           r11,
    output logic [31:0]           r12,
    output logic [31:0]           r20,
    output logic [31:0]           r21,
    output logic [31:0]           r22
);

    localparam int CW     = 2 * ELEM_WIDTH + 1;
    localparam int SIDE_W = 9 * CW + 2;
    localparam int NDIV   = m3inv_pkg::DIV_BITS;
    localparam int OUT_W  = 9 * m3inv_pkg::RES_W + 1;

    logic                         en;
    logic [8:0][ELEM_WIDTH-1:0]   m_in;
    logic                         fr_valid;
    logic [8:0][CW-1:0]           fr_cof;
    logic                         fr_neg;
    logic                         fr_zero;
    m3inv_pkg::div_t              fr_div;
    logic                         v_ch [NDIV+1];
    m3inv_pkg::div_t              d_ch [NDIV+1];
    logic [SIDE_W-1:0]            s_ch [NDIV+1];
    logic [8:0][CW-1:0]           sc_cof;
    logic                         sc_valid;
    logic                         sc_singular;
    logic [8:0][m3inv_pkg::RES_W-1:0] sc_res;
    logic [OUT_W-1:0]             ldata;
    logic [OUT_W-1:0]             od_reg;
    logic [OUT_W-1:0]             sd_reg;
    logic                         ov_reg;
    logic                         sv_reg;
    logic                         take;

    assign en       = !sv_reg;
    assign in_ready = en;
    assign m_in     = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

    m3inv_front #(
        .W (ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .func      (func),
        .m         (m_in),
        .out_valid (fr_valid),
        .cof       (fr_cof),
        .det_neg   (fr_neg),
        .det_zero  (fr_zero),
        .dstate    (fr_div)
    );

    assign v_ch[0] = fr_valid;
    assign d_ch[0] = fr_div;
    assign s_ch[0] = {fr_zero, fr_neg, fr_cof};

    for (genvar g = 0; g < NDIV; g++)
    begin : g_div
        m3inv_div_step #(
            .BIT    (NDIV - 1 - g),
            .SIDE_W (SIDE_W)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_ch[g]),
            .in_div    (d_ch[g]),
            .in_side   (s_ch[g]),
            .out_valid (v_ch[g+1]),
            .out_div   (d_ch[g+1]),
            .out_side  (s_ch[g+1])
        );
    end

    assign sc_cof = s_ch[NDIV][9*CW-1:0];

    m3inv_scale #(
        .CW (CW)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_ch[NDIV]),
        .cof       (sc_cof),
        .quo       (d_ch[NDIV].quo),
        .det_neg   (s_ch[NDIV][9*CW]),
        .det_zero  (s_ch[NDIV][9*CW+1]),
        .out_valid (sc_valid),
        .singular  (sc_singular),
        .res       (sc_res)
    );

    assign ldata = {sc_singular, sc_res};
    assign take  = ov_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (sv_reg)
        begin
            if (take)
            begin
                sv_reg <= 1'b0;
            end
        end
        else if (!ov_reg || take)
        begin
            ov_reg <= sc_valid;
        end
        else if (sc_valid)
        begin
            sv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_reg)
        begin
            if (take)
            begin
                od_reg <= sd_reg;
            end
        end
        else if (!ov_reg || take)
        begin
            od_reg <= ldata;
        end
        else
        begin
            sd_reg <= ldata;
        end
    end

    assign out_valid = ov_reg;
    assign singular  = od_reg[OUT_W-1];
    assign r00       = od_reg[31:0];
    assign r01       = od_reg[63:32];
    assign r02       = od_reg[95:64];
    assign r10       = od_reg[127:96];
    assign r11       = od_reg[159:128];
    assign r12       = od_reg[191:160];
    assign r20       = od_reg[223:192];
    assign r21       = od_reg[255:224];
    assign r22       = od_reg[287:256];

endmodule

// ----- tb/sv/matrix3_inverse_core_tb.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse_core_tb
// Drives 3x3 Q8.8 matrices into the inverse core with random gaps and output
// stalls, predicts each inverse or transposed inverse in fixed point and
// compares every result field by field in order of arrival.
// ----------------------------------------------------------------------------
module matrix3_inverse_core_tb;

    localparam int EW = 16;
    localparam int LATENCY = 64;
    localparam int RANDOM_ITEMS = 1630;

    typedef struct {
        logic          func;
        logic [EW-1:0] m [9];
        int unsigned   gap;
        bit            drain;
    } mat_item_t;

    typedef struct {
        logic        singular;
        logic [31:0] r [9];
    } inv_result_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic          func;
    logic [EW-1:0] m [9];
    logic          out_valid;
    logic          out_ready;
    logic          singular;
    logic [31:0]   r [9];

    mat_item_t   pending_items [$];
    inv_result_t expected_inverses [$];
    int          error_count = 0;
    int          accepted_count = 0;
    bit          long_hold;

    matrix3_inverse_core #(.ELEM_WIDTH(EW)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .m00(m[0]), .m01(m[1]), .m02(m[2]),
        .m10(m[3]), .m11(m[4]), .m12(m[5]),
        .m20(m[6]), .m21(m[7]), .m22(m[8]),
        .out_valid(out_valid), .out_ready(out_ready), .singular(singular),
        .r00(r[0]), .r01(r[1]), .r02(r[2]),
        .r10(r[3]), .r11(r[4]), .r12(r[5]),
        .r20(r[6]), .r21(r[7]), .r22(r[8])
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // (c * rcp) >>> 32 with saturation to 32 bits
    function automatic logic [31:0] scale_cofactor(longint c, longint rcp);
        logic signed [127:0] p;
        logic signed [127:0] q;
        p = 128'(signed'(c)) * 128'(signed'(rcp));
        q = p >>> 32;
        if (q > 128'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        if (q < -128'sh8000_0000)
            return 32'h8000_0000;
        return q[31:0];
    endfunction

    function automatic inv_result_t predict_inverse(logic f, logic [EW-1:0] mm [9]);
        inv_result_t res;
        longint a [3][3];
        longint c [3][3];
        longint det;
        longint rcp;
        longint dmag;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = longint'(signed'(mm[i*3+j]));
        c[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
        c[0][1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
        c[0][2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
        c[1][0] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
        c[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
        c[1][2] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
        c[2][0] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
        c[2][1] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
        c[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
        det = a[0][0]*c[0][0] + a[0][1]*c[1][0] + a[0][2]*c[2][0];
        res.singular = (det == 0);
        for (int k = 0; k < 9; k++)
            res.r[k] = '0;
        if (det != 0)
        begin
            dmag = (det < 0) ? -det : det;
            rcp = (64'sd1 <<< 56) / dmag;
            if (det < 0)
                rcp = -rcp;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    res.r[i*3+j] = scale_cofactor(f ? c[j][i] : c[i][j], rcp);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [EW-1:0] random_elem();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 1024)) - 512);
            3: return 16'(int'($urandom_range(0, 4096)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_matrix(logic f, logic [EW-1:0] mm [9], bit drain);
        mat_item_t it;
        it.func = f;
        it.m = mm;
        it.drain = drain;
        it.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        pending_items.push_back(it);
    endtask

    // accept flag sampled at the rising edge, used at the next falling edge
    logic in_ready_q;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_q <= 1'b1;
        else
            in_ready_q <= !(in_valid && in_ready) && in_valid ? 1'b0 : 1'b1;
    end

    // driver
    int unsigned gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            func <= 1'b0;
            for (int k = 0; k < 9; k++)
                m[k] <= '0;
        end
        else if (!(in_valid && !in_ready_q))
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_inverses.size() != 0))
            begin
                mat_item_t it;
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                func <= it.func;
                for (int k = 0; k < 9; k++)
                    m[k] <= it.m[k];
                gap_left <= it.gap;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_inverses.push_back(predict_inverse(func, m));
            accepted_count++;
        end
    end

    // long receiver hold while the sender keeps offering items
    initial
    begin
        long_hold = 1'b0;
        wait (accepted_count >= 320);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
    end

    // receiver stalls
    int unsigned stall_left;
    int unsigned stall_draw;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (long_hold)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            stall_draw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            out_ready <= (stall_draw == 0);
            stall_left <= stall_draw;
        end
        else if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_inverses.size() == 0)
            begin
                $display("result arrived with nothing expected");
                error_count++;
            end
            else
            begin
                inv_result_t e;
                e = expected_inverses.pop_front();
                if (singular !== e.singular)
                    report_mismatch("singular", 32'(singular), 32'(e.singular));
                for (int k = 0; k < 9; k++)
                    if (r[k] !== e.r[k])
                        report_mismatch($sformatf("r%0d%0d", k / 3, k % 3), r[k], e.r[k]);
            end
        end
    end

    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [EW-1:0] mm [9];
        int            total_items;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identity, zero, extremes, tiny det, negative det, dependent rows
        for (int f = 0; f < 2; f++)
        begin
            mm = '{16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
                   16'h0000, 16'h0000, 16'h0000, 16'h0100};
            queue_matrix(1'(f), mm, 1'b0);
            mm = '{default: 16'h0000};
            queue_matrix(1'(f), mm, 1'b0);
            mm = '{default: 16'h7FFF};
            queue_matrix(1'(f), mm, 1'b0);
            mm = '{16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
                   16'h0000, 16'h0000, 16'h0000, 16'h8000};
            queue_matrix(1'(f), mm, 1'b0);
            mm = '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF,
                   16'h0000, 16'h0000, 16'h0000, 16'h7FFF};
            queue_matrix(1'(f), mm, 1'b0);
            mm = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
                   16'h0000, 16'h0000, 16'h0000, 16'h0001};
            queue_matrix(1'(f), mm, 1'b0);
            mm = '{16'h0001, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                   16'h7FFF, 16'h0000, 16'h0000, 16'h0001};
            queue_matrix(1'(f), mm, 1'b0);
            mm = '{16'h0200, 16'h0100, 16'h0300, 16'hFF00, 16'h0400,
                   16'h0100, 16'h0100, 16'hFE00, 16'hFD00};
            queue_matrix(1'(f), mm, 1'b0);
            mm = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                   16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h8000};
            queue_matrix(1'(f), mm, 1'b0);
            mm = '{16'h0100, 16'h0200, 16'h0300, 16'h0200, 16'h0400,
                   16'h0600, 16'h0001, 16'h0002, 16'h0003};
            queue_matrix(1'(f), mm, 1'b0);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            for (int k = 0; k < 9; k++)
                mm[k] = random_elem();
            if ($urandom_range(0, 9) == 0)
                for (int k = 0; k < 3; k++)
                    mm[6 + k] = mm[k];
            queue_matrix(1'($urandom_range(0, 1)), mm, n == 600);
            if (n == 300)
            begin
                for (int j = 0; j < 150; j++)
                begin
                    for (int k = 0; k < 9; k++)
                        mm[k] = random_elem();
                    queue_matrix(1'($urandom_range(0, 1)), mm, 1'b0);
                    pending_items[$].gap = 0;
                end
            end
        end
        total_items = pending_items.size();

        wait (accepted_count == total_items);
        wait (expected_inverses.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/m3inv_pkg.sv
rtl/core/m3inv_front.sv
rtl/core/m3inv_div_step.sv
rtl/core/m3inv_scale.sv
rtl/core/matrix3_inverse_core.sv
tb/sv/matrix3_inverse_core_tb.sv
